>>> sv/ufef_pkg.sv
// Shared types, constants and the control store for the union-find edge filter.
// No dependencies; every other file imports this package.
package ufef_pkg;

    localparam int MAX_VERTICES = 1024;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = 11;
    localparam int CNT_W        = 10;
    localparam int PADDR_W      = 2;
    localparam int PDATA_W      = 32;

    localparam logic [CNT_W-1:0]   COUNT_MAX    = '1;
    localparam logic [VCNT_W-1:0]  VCOUNT_RESET = 11'd1024;
    localparam logic [PADDR_W-1:0] ADDR_VCOUNT  = '0;
    localparam logic [VTX_W-1:0]   LAST_VERTEX  = VTX_W'(MAX_VERTICES - 1);

    localparam logic OP_EDGE    = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic             op;
        logic [VTX_W-1:0] vertex_a;
        logic [VTX_W-1:0] vertex_b;
    } t_in_word;

    typedef struct packed {
        logic             accepted;
        logic [VTX_W-1:0] edge_a;
        logic [VTX_W-1:0] edge_b;
        logic [CNT_W-1:0] tree_edges;
        logic             tree_complete;
        logic             out_of_range;
    } t_out_word;

    // program steps
    typedef enum logic [3:0] {
        S_CLR, S_CLR_END, S_FIN, S_IDLE, S_DEC, S_RANGE,
        S_FA, S_CA0, S_CA, S_FB0, S_FB, S_LINK
    } t_step;

    // jump conditions: taken -> target, else fall through
    typedef enum logic [3:0] {
        C_NEVER, C_ALWAYS, C_NOT_CLR_LAST, C_NO_ITEM, C_NOT_OUT_FREE,
        C_NOT_ACCEPT, C_RESTART, C_OOR, C_NOT_ROOT, C_NOT_CA_END
    } t_cond;

    typedef enum logic [1:0] {R_A, R_B, R_RD}        t_rsel;
    typedef enum logic [1:0] {W_CUR, W_RA, W_CLR}    t_wsel;
    typedef enum logic [1:0] {D_RA, D_RB, D_CLR}     t_dsel;
    typedef enum logic [1:0] {CUR_HOLD, CUR_A, CUR_B, CUR_RD} t_csel;

    typedef struct packed {
        t_cond cond;
        t_step target;
        logic  in_rdy;
        logic  rd_en;
        t_rsel rsel;
        logic  we;
        t_wsel wsel;
        t_dsel dsel;
        t_csel csel;
        logic  ld_ra;
        logic  ld_rb;
        logic  link;
        logic  clr_step;
        logic  clr_count;
        logic  out_ld;
    } t_ucode;

    typedef struct packed {
        logic clr_last;
        logic item;
        logic out_free;
        logic accept;
        logic restart;
        logic oor;
        logic not_root;
        logic ca_end;
    } t_flags;

    localparam t_ucode UC_NOP = '{
        cond: C_NEVER, target: S_IDLE, in_rdy: 1'b0, rd_en: 1'b0, rsel: R_A,
        we: 1'b0, wsel: W_CUR, dsel: D_RA, csel: CUR_HOLD, ld_ra: 1'b0,
        ld_rb: 1'b0, link: 1'b0, clr_step: 1'b0, clr_count: 1'b0, out_ld: 1'b0
    };

    // control store
    function automatic t_ucode ucode_rom(input t_step s);
        t_ucode w;
        w = UC_NOP;
        case (s)
            S_CLR: begin
                w.we = 1'b1; w.wsel = W_CLR; w.dsel = D_CLR; w.clr_step = 1'b1;
                w.cond = C_NOT_CLR_LAST; w.target = S_CLR;
            end
            S_CLR_END: begin
                w.clr_count = 1'b1; w.cond = C_NO_ITEM; w.target = S_IDLE;
            end
            S_FIN: begin
                w.out_ld = 1'b1; w.cond = C_NOT_OUT_FREE; w.target = S_FIN;
            end
            S_IDLE: begin
                w.in_rdy = 1'b1; w.cond = C_NOT_ACCEPT; w.target = S_IDLE;
            end
            S_DEC: begin
                w.cond = C_RESTART; w.target = S_CLR;
            end
            S_RANGE: begin
                w.rd_en = 1'b1; w.rsel = R_A; w.csel = CUR_A;
                w.cond = C_OOR; w.target = S_FIN;
            end
            S_FA: begin
                w.rd_en = 1'b1; w.rsel = R_RD; w.csel = CUR_RD; w.ld_ra = 1'b1;
                w.cond = C_NOT_ROOT; w.target = S_FA;
            end
            S_CA0: begin
                w.rd_en = 1'b1; w.rsel = R_A; w.csel = CUR_A;
            end
            S_CA: begin
                w.rd_en = 1'b1; w.rsel = R_RD; w.csel = CUR_RD;
                w.we = 1'b1; w.wsel = W_CUR; w.dsel = D_RA;
                w.cond = C_NOT_CA_END; w.target = S_CA;
            end
            S_FB0: begin
                w.rd_en = 1'b1; w.rsel = R_B; w.csel = CUR_B;
            end
            S_FB: begin
                w.rd_en = 1'b1; w.rsel = R_RD; w.csel = CUR_RD; w.ld_rb = 1'b1;
                w.cond = C_NOT_ROOT; w.target = S_FB;
            end
            S_LINK: begin
                w.we = 1'b1; w.wsel = W_RA; w.dsel = D_RB; w.link = 1'b1;
                w.cond = C_ALWAYS; w.target = S_FIN;
            end
            default: begin
                w.cond = C_ALWAYS; w.target = S_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> sv/ufef_if.sv
// Valid/ready channel interfaces for edge words in and result words out.
// Depends on ufef_pkg for the payload types.
interface ufef_in_if;
    import ufef_pkg::*;
    logic     valid;
    logic     ready;
    t_in_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface ufef_out_if;
    import ufef_pkg::*;
    logic      valid;
    logic      ready;
    t_out_word payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/ufef_useq.sv
// Step counter and jump logic of the microcoded sequencer.
// Depends on ufef_pkg (control store, flag and step types).
module ufef_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ufef_pkg::t_flags i_flags,
    output ufef_pkg::t_ucode o_uc
);
    import ufef_pkg::*;

    t_step  r_pc;
    t_step  n_pc;
    t_ucode uc;
    logic   take;

    assign uc   = ucode_rom(r_pc);
    assign o_uc = uc;

    always_comb begin
        case (uc.cond)
            C_NEVER:        take = 1'b0;
            C_ALWAYS:       take = 1'b1;
            C_NOT_CLR_LAST: take = !i_flags.clr_last;
            C_NO_ITEM:      take = !i_flags.item;
            C_NOT_OUT_FREE: take = !i_flags.out_free;
            C_NOT_ACCEPT:   take = !i_flags.accept;
            C_RESTART:      take = i_flags.restart;
            C_OOR:          take = i_flags.oor;
            C_NOT_ROOT:     take = i_flags.not_root;
            C_NOT_CA_END:   take = !i_flags.ca_end;
            default:        take = 1'b0;
        endcase
        n_pc = take ? uc.target : t_step'(4'(r_pc + 4'd1));
    end

    // reset starts with the clearing sweep of the parent table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= S_CLR;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

>>> sv/ufef_dpath.sv
// Datapath: parent memory, walk registers, edge count and output register.
// Depends on ufef_pkg and the channel interfaces in ufef_if.sv.
module ufef_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  ufef_pkg::t_ucode             i_uc,
    input  logic [ufef_pkg::VCNT_W-1:0]  i_vcount,
    ufef_in_if.sink                      i_edge,
    ufef_out_if.source                   o_result,
    output ufef_pkg::t_flags             o_flags
);
    import ufef_pkg::*;

    logic [VTX_W-1:0] r_parent [MAX_VERTICES];
    logic [VTX_W-1:0] r_rd;
    logic [VTX_W-1:0] r_cur;
    logic [VTX_W-1:0] r_ra;
    logic [VTX_W-1:0] r_rb;
    logic [VTX_W-1:0] r_a;
    logic [VTX_W-1:0] r_b;
    logic             r_op;
    logic             r_acc;
    logic             r_item;
    logic [VTX_W-1:0] r_clr;
    logic [CNT_W-1:0] r_count;
    logic             r_ovalid;
    t_out_word        r_oword;

    logic [VTX_W-1:0] raddr;
    logic [VTX_W-1:0] waddr;
    logic [VTX_W-1:0] wdata;
    logic             accept;
    logic             out_free;
    logic             oor;
    logic             joined;
    logic             complete;

    assign accept   = i_edge.valid && i_uc.in_rdy;
    assign out_free = !r_ovalid || o_result.ready;
    assign oor      = ({1'b0, r_a} >= i_vcount) || ({1'b0, r_b} >= i_vcount);
    assign joined   = r_ra != r_rb;
    assign complete = (({1'b0, r_count}) + 11'd1) >= i_vcount;

    assign i_edge.ready     = i_uc.in_rdy;
    assign o_result.valid   = r_ovalid;
    assign o_result.payload = r_oword;

    assign o_flags = '{
        clr_last: r_clr == LAST_VERTEX,
        item:     r_item,
        out_free: out_free,
        accept:   accept,
        restart:  r_op == OP_RESTART,
        oor:      oor,
        not_root: r_rd != r_cur,
        ca_end:   (r_rd == r_cur) || (r_rd == r_ra)
    };

    always_comb begin
        case (i_uc.rsel)
            R_A:     raddr = r_a;
            R_B:     raddr = r_b;
            R_RD:    raddr = r_rd;
            default: raddr = r_rd;
        endcase
        case (i_uc.wsel)
            W_CUR:   waddr = r_cur;
            W_RA:    waddr = r_ra;
            W_CLR:   waddr = r_clr;
            default: waddr = r_clr;
        endcase
        case (i_uc.dsel)
            D_RA:    wdata = r_ra;
            D_RB:    wdata = r_rb;
            D_CLR:   wdata = r_clr;
            default: wdata = r_clr;
        endcase
    end

    // parent memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_uc.we) begin
            r_parent[waddr] <= wdata;
        end
        if (i_uc.rd_en) begin
            r_rd <= r_parent[raddr];
        end
    end

    // walk and item registers
    always_ff @(posedge i_clk) begin
        case (i_uc.csel)
            CUR_A:   r_cur <= r_a;
            CUR_B:   r_cur <= r_b;
            CUR_RD:  r_cur <= r_rd;
            default: r_cur <= r_cur;
        endcase
        if (i_uc.ld_ra) begin
            r_ra <= r_rd;
        end
        if (i_uc.ld_rb) begin
            r_rb <= r_rd;
        end
        if (accept) begin
            r_op <= i_edge.payload.op;
            r_a  <= i_edge.payload.vertex_a;
            r_b  <= i_edge.payload.vertex_b;
        end
        if (accept) begin
            r_acc <= 1'b0;
        end else if (i_uc.link) begin
            r_acc <= joined;
        end
        if (i_uc.out_ld && out_free) begin
            r_oword.accepted      <= r_acc;
            r_oword.edge_a        <= r_a;
            r_oword.edge_b        <= r_b;
            r_oword.tree_edges    <= r_count;
            r_oword.tree_complete <= complete;
            r_oword.out_of_range  <= (r_op == OP_EDGE) && oor;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item   <= 1'b0;
            r_clr    <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_item <= 1'b1;
            end else if (i_uc.out_ld && out_free) begin
                r_item <= 1'b0;
            end
            if (i_uc.clr_step) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_uc.clr_count) begin
                r_count <= '0;
            end else if (i_uc.link && joined && (r_count != COUNT_MAX)) begin
                r_count <= r_count + 1'b1;
            end
            if (i_uc.out_ld && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_result.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

>>> sv/union_find_edge_filter_unit.sv
// Top level of the union-find edge filter: config register, sequencer, datapath.
// Depends on ufef_pkg, ufef_if.sv, ufef_useq and ufef_dpath.
//
//   channel    dir  handshake        word
//   i_edge     in   valid/ready      op, vertex_a, vertex_b
//   o_result   out  valid/ready      accepted, edge_a, edge_b, tree_edges,
//                                    tree_complete, out_of_range
//   APB        in   psel/penable     vertex_count at byte address 0
//
// Cycles: an edge takes 10 + (hops to root of a) + (compressed hops from a)
//   + (hops to root of b) cycles, set by the one-hop-per-cycle walk through the
//   single read port of the parent memory; an out-of-range edge takes 4.
// A restart takes MAX_VERTICES + 4 cycles: the sweep rewrites one entry a cycle.
// Reset: after i_rst_n rises the same sweep runs for MAX_VERTICES + 1 cycles
//   with i_edge.ready low; APB writes are taken throughout.
// Stalls: one result word is held in the output register; the next edge is
//   accepted and worked on meanwhile, and waits only at its own hand-over.
module union_find_edge_filter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ufef_in_if.sink                       i_edge,
    ufef_out_if.source                    o_result,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [ufef_pkg::PADDR_W-1:0]  i_paddr,
    input  logic [ufef_pkg::PDATA_W-1:0]  i_pwdata,
    output logic [ufef_pkg::PDATA_W-1:0]  o_prdata,
    output logic                          o_pready
);
    import ufef_pkg::*;

    logic [VCNT_W-1:0] r_vcount;
    t_ucode            uc;
    t_flags            flags;
    logic              cfg_wr;

    // APB: zero-wait, write lands on the access cycle
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && (i_paddr == ADDR_VCOUNT);
    assign o_prdata = (i_paddr == ADDR_VCOUNT) ? PDATA_W'(r_vcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= VCOUNT_RESET;
        end else if (cfg_wr) begin
            r_vcount <= i_pwdata[VCNT_W-1:0];
        end
    end

    ufef_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (flags),
        .o_uc    (uc)
    );

    ufef_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_uc     (uc),
        .i_vcount (r_vcount),
        .i_edge   (i_edge),
        .o_result (o_result),
        .o_flags  (flags)
    );

    // a tree edge is never also a range reject
    a_acc_not_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.accepted |-> !o_result.payload.out_of_range)
        else $error("accepted edge flagged out of range");

    // a tree edge always leaves a non-zero count
    a_acc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && o_result.payload.accepted |-> o_result.payload.tree_edges != '0)
        else $error("accepted edge with zero tree count");

    // no new word is taken while one is still in flight
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_edge.ready |-> !flags.item)
        else $error("input ready with an item in flight");

    // once an edge is taken the sequencer leaves the wait step
    a_accept_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_edge.valid && i_edge.ready |=> !i_edge.ready)
        else $error("sequencer stayed ready after accepting a word");

endmodule
